>>> rtl/core/assert_macros.svh
// Assertion macros shared by the contour crossing RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/core/ccec_pkg.sv
// Shared constants and types of the contour cell edge crossing block.
package ccec_pkg;

    localparam int MAX_COLUMNS    = 1024;
    localparam int MAX_ROWS       = 1024;
    localparam int SAMPLE_BITS    = 16;
    localparam int FRACTION_BITS  = 12;

    localparam int COL_BITS       = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS       = $clog2(MAX_ROWS);
    localparam int SIZE_BITS      = 11;
    localparam int COORD_BITS     = 22;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int EDGE_BITS      = 2;
    localparam int DIFF_BITS      = SAMPLE_BITS + 1;
    localparam int MAG_BITS       = SAMPLE_BITS;
    localparam int REM_BITS       = MAG_BITS + 1;
    localparam int QUOT_BITS      = FRACTION_BITS + 1;
    localparam int STEP_BITS      = $clog2(QUOT_BITS);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LEVEL   = 2'd0,
        CFG_COLUMNS = 2'd1,
        CFG_ROWS    = 2'd2
    } cfg_index_t;

    typedef enum logic [EDGE_BITS-1:0] {
        EDGE_TOP    = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_BOTTOM = 2'd2,
        EDGE_LEFT   = 2'd3
    } edge_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SETUP,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/core/ccec_sample_if.sv
// Sample channel: valid/ready handshake carrying one grid sample per word.
interface ccec_sample_if import ccec_pkg::*; ();

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);

endinterface

>>> rtl/core/ccec_point_if.sv
// Point channel: valid/ready handshake carrying one crossing point per word.
interface ccec_point_if import ccec_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic [COL_BITS-1:0]   cell_column;
    logic [ROW_BITS-1:0]   cell_row;
    logic [EDGE_BITS-1:0]  edge_id;
    logic                  last_point;

    modport source (output valid, output point_x, output point_y, output cell_column,
                    output cell_row, output edge_id, output last_point, input ready);
    modport sink (input valid, input point_x, input point_y, input cell_column,
                  input cell_row, input edge_id, input last_point, output ready);

endinterface

>>> rtl/core/contour_cell_edge_crossings_core.sv
// Contour cell edge crossing core: line buffer, edge tests and crossing interpolation.
//
// Usage: grid samples enter row-major on the samples channel, one word per sample.
// From the second row and second column on, each sample closes a cell and the
// block emits one word on the points channel for every crossed edge, in the order
// top, right, bottom, left, with last_point set on the final word of the cell.
// Configuration (contour_level, grid_columns, grid_rows) is written through
// cfg_we / cfg_index / cfg_data while the block is idle; index 3 is ignored.
// A sample is taken in IDLE and the previous row is read from the line buffer
// RAM in that same cycle; the edge tests follow in READ. Each crossing passes
// through SETUP, the shared bit-per-cycle restoring divider in DIV and EMIT,
// which loads the output register; while the receiver keeps up, the divider
// sets the sustained rate. A new sample is taken only in IDLE, once every
// crossing of the last one is loaded. The output register holds a finished
// word while the next sample is taken; when the receiver stalls, the block
// waits before loading the next point. Reset returns the registers to level 0
// and 1024 x 1024, clears the counters and the held corner samples and drops
// any pending word; the line buffer is not cleared, the first row rewrites it.
`include "assert_macros.svh"

module contour_cell_edge_crossings_core import ccec_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    ccec_sample_if.sink               samples,
    ccec_point_if.source              points
);

    function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                        input logic [SIZE_BITS-1:0] hi);
        logic [SIZE_BITS-1:0] r;
        begin
            r = v;
            if (v < SIZE_BITS'(2))
            begin
                r = SIZE_BITS'(2);
            end
            else if (v > hi)
            begin
                r = hi;
            end
            return r;
        end
    endfunction

    function automatic logic crossed(input logic signed [SAMPLE_BITS-1:0] a,
                                     input logic signed [SAMPLE_BITS-1:0] b,
                                     input logic signed [SAMPLE_BITS-1:0] lv);
        return ((a <= lv) && (lv < b)) || ((b <= lv) && (lv < a));
    endfunction

    function automatic logic [MAG_BITS-1:0] abs_diff(input logic signed [SAMPLE_BITS-1:0] a,
                                                     input logic signed [SAMPLE_BITS-1:0] b);
        logic [DIFF_BITS-1:0] d;
        begin
            d = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
            return d[DIFF_BITS-1] ? MAG_BITS'(-d) : MAG_BITS'(d);
        end
    endfunction

    function automatic edge_t first_edge(input logic [3:0] m);
        edge_t e;
        begin
            e = EDGE_TOP;
            for (int k = 3; k >= 0; k--)
            begin
                if (m[k])
                begin
                    e = edge_t'(EDGE_BITS'(k));
                end
            end
            return e;
        end
    endfunction

    logic signed [SAMPLE_BITS-1:0] line_mem [MAX_COLUMNS];

    state_t                        state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] level_reg;
    logic [SIZE_BITS-1:0]          columns_reg, rows_reg;
    logic [COL_BITS-1:0]           col_cnt_reg, col_cnt_next;
    logic [ROW_BITS-1:0]           row_cnt_reg, row_cnt_next;
    logic signed [SAMPLE_BITS-1:0] left_reg, left_next;
    logic signed [SAMPLE_BITS-1:0] top_left_reg, top_left_next;
    logic [3:0]                    mask_reg, mask_next;
    logic                          out_valid_reg, out_valid_next;

    logic signed [SAMPLE_BITS-1:0] above_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                          closes_reg, closes_next;
    logic [COL_BITS-1:0]           cell_col_reg, cell_col_next;
    logic [ROW_BITS-1:0]           cell_row_reg, cell_row_next;
    logic signed [SAMPLE_BITS-1:0] z_tl_reg, z_tl_next;
    logic signed [SAMPLE_BITS-1:0] z_tr_reg, z_tr_next;
    logic signed [SAMPLE_BITS-1:0] z_br_reg, z_br_next;
    logic signed [SAMPLE_BITS-1:0] z_bl_reg, z_bl_next;
    edge_t                         edge_reg, edge_next;
    logic [REM_BITS-1:0]           rem_reg, rem_next;
    logic [MAG_BITS-1:0]           den_reg, den_next;
    logic [QUOT_BITS-1:0]          quo_reg, quo_next;
    logic [STEP_BITS-1:0]          step_reg, step_next;
    logic [COORD_BITS-1:0]         px_reg, px_next;
    logic [COORD_BITS-1:0]         py_reg, py_next;
    logic [COL_BITS-1:0]           ocol_reg, ocol_next;
    logic [ROW_BITS-1:0]           orow_reg, orow_next;
    edge_t                         oedge_reg, oedge_next;
    logic                          olast_reg, olast_next;

    logic                          in_fire;

    assign samples.ready = (state_reg == ST_IDLE);
    assign in_fire       = samples.valid && samples.ready;

    assign points.valid       = out_valid_reg;
    assign points.point_x     = px_reg;
    assign points.point_y     = py_reg;
    assign points.cell_column = ocol_reg;
    assign points.cell_row    = orow_reg;
    assign points.edge_id     = oedge_reg;
    assign points.last_point  = olast_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            line_mem[col_cnt_reg] <= samples.sample;
            above_reg             <= line_mem[col_cnt_reg];
        end
    end

    always_comb
    begin
        logic [SIZE_BITS-1:0]   cols;
        logic [SIZE_BITS-1:0]   rows;
        logic [3:0]             m;
        logic [3:0]             rest;
        logic signed [SAMPLE_BITS-1:0] za;
        logic signed [SAMPLE_BITS-1:0] zb;
        logic                   ge;
        logic [REM_BITS-1:0]    diff;
        logic [REM_BITS-1:0]    kept;
        logic [COORD_BITS-1:0]  jx;
        logic [COORD_BITS-1:0]  iy;
        logic [COORD_BITS-1:0]  one;
        logic [COORD_BITS-1:0]  tq;

        state_next     = state_reg;
        col_cnt_next   = col_cnt_reg;
        row_cnt_next   = row_cnt_reg;
        left_next      = left_reg;
        top_left_next  = top_left_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && !points.ready;
        sample_next    = sample_reg;
        closes_next    = closes_reg;
        cell_col_next  = cell_col_reg;
        cell_row_next  = cell_row_reg;
        z_tl_next      = z_tl_reg;
        z_tr_next      = z_tr_reg;
        z_br_next      = z_br_reg;
        z_bl_next      = z_bl_reg;
        edge_next      = edge_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ocol_next      = ocol_reg;
        orow_next      = orow_reg;
        oedge_next     = oedge_reg;
        olast_next     = olast_reg;

        cols = clamp_size(columns_reg, SIZE_BITS'(MAX_COLUMNS));
        rows = clamp_size(rows_reg, SIZE_BITS'(MAX_ROWS));
        m    = '0;
        rest = '0;
        za   = z_tl_reg;
        zb   = z_tr_reg;
        ge   = rem_reg >= REM_BITS'(den_reg);
        diff = rem_reg - REM_BITS'(den_reg);
        kept = ge ? diff : rem_reg;
        jx   = COORD_BITS'({cell_col_reg, {FRACTION_BITS{1'b0}}});
        iy   = COORD_BITS'({cell_row_reg, {FRACTION_BITS{1'b0}}});
        one  = COORD_BITS'(1) << FRACTION_BITS;
        tq   = COORD_BITS'(quo_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    sample_next   = samples.sample;
                    closes_next   = (row_cnt_reg != '0) && (col_cnt_reg != '0);
                    cell_col_next = col_cnt_reg - COL_BITS'(1);
                    cell_row_next = row_cnt_reg - ROW_BITS'(1);
                    if (SIZE_BITS'(col_cnt_reg) >= cols - SIZE_BITS'(1))
                    begin
                        col_cnt_next = '0;
                        if (SIZE_BITS'(row_cnt_reg) >= rows - SIZE_BITS'(1))
                        begin
                            row_cnt_next = '0;
                        end
                        else
                        begin
                            row_cnt_next = row_cnt_reg + ROW_BITS'(1);
                        end
                    end
                    else
                    begin
                        col_cnt_next = col_cnt_reg + COL_BITS'(1);
                    end
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                m[EDGE_TOP]    = crossed(top_left_reg, above_reg, level_reg);
                m[EDGE_RIGHT]  = crossed(above_reg, sample_reg, level_reg);
                m[EDGE_BOTTOM] = crossed(sample_reg, left_reg, level_reg);
                m[EDGE_LEFT]   = crossed(left_reg, top_left_reg, level_reg);
                z_tl_next      = top_left_reg;
                z_tr_next      = above_reg;
                z_br_next      = sample_reg;
                z_bl_next      = left_reg;
                top_left_next  = above_reg;
                left_next      = sample_reg;
                mask_next      = closes_reg ? m : 4'b0000;
                state_next     = (closes_reg && (m != 4'b0000)) ? ST_SETUP : ST_IDLE;
            end
            ST_SETUP:
            begin
                edge_next = first_edge(mask_reg);
                case (first_edge(mask_reg))
                    EDGE_TOP:
                    begin
                        za = z_tl_reg;
                        zb = z_tr_reg;
                    end
                    EDGE_RIGHT:
                    begin
                        za = z_tr_reg;
                        zb = z_br_reg;
                    end
                    EDGE_BOTTOM:
                    begin
                        za = z_br_reg;
                        zb = z_bl_reg;
                    end
                    EDGE_LEFT:
                    begin
                        za = z_bl_reg;
                        zb = z_tl_reg;
                    end
                    default:
                    begin
                        za = z_tl_reg;
                        zb = z_tr_reg;
                    end
                endcase
                rem_next   = REM_BITS'(abs_diff(level_reg, za));
                den_next   = abs_diff(zb, za);
                quo_next   = '0;
                step_next  = STEP_BITS'(QUOT_BITS - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                quo_next = {quo_reg[QUOT_BITS-2:0], ge};
                rem_next = kept << 1;
                if (step_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next = step_reg - STEP_BITS'(1);
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || points.ready)
                begin
                    case (edge_reg)
                        EDGE_TOP:
                        begin
                            px_next = jx + tq;
                            py_next = iy;
                        end
                        EDGE_RIGHT:
                        begin
                            px_next = jx + one;
                            py_next = iy + tq;
                        end
                        EDGE_BOTTOM:
                        begin
                            px_next = jx + one - tq;
                            py_next = iy + one;
                        end
                        EDGE_LEFT:
                        begin
                            px_next = jx;
                            py_next = iy + one - tq;
                        end
                        default:
                        begin
                            px_next = jx;
                            py_next = iy;
                        end
                    endcase
                    rest           = mask_reg & ~(4'b0001 << edge_reg);
                    mask_next      = rest;
                    ocol_next      = cell_col_reg;
                    orow_next      = cell_row_reg;
                    oedge_next     = edge_reg;
                    olast_next     = (rest == 4'b0000);
                    out_valid_next = 1'b1;
                    state_next     = (rest == 4'b0000) ? ST_IDLE : ST_SETUP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= '0;
            columns_reg   <= SIZE_BITS'(MAX_COLUMNS);
            rows_reg      <= SIZE_BITS'(MAX_ROWS);
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            left_reg      <= '0;
            top_left_reg  <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            left_reg      <= left_next;
            top_left_reg  <= top_left_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LEVEL:   level_reg   <= cfg_data[SAMPLE_BITS-1:0];
                    CFG_COLUMNS: columns_reg <= cfg_data[SIZE_BITS-1:0];
                    CFG_ROWS:    rows_reg    <= cfg_data[SIZE_BITS-1:0];
                    default:     level_reg   <= level_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        closes_reg   <= closes_next;
        cell_col_reg <= cell_col_next;
        cell_row_reg <= cell_row_next;
        z_tl_reg     <= z_tl_next;
        z_tr_reg     <= z_tr_next;
        z_br_reg     <= z_br_next;
        z_bl_reg     <= z_bl_next;
        edge_reg     <= edge_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        ocol_reg     <= ocol_next;
        orow_reg     <= orow_next;
        oedge_reg    <= oedge_next;
        olast_reg    <= olast_next;
    end

    `ASSERT_NXT(a_div_done, clk, rst_n, state_reg == ST_DIV && step_reg == STEP_BITS'(0), state_reg == ST_EMIT)
    `ASSERT_IMP(a_quot_range, clk, rst_n, state_reg == ST_EMIT, quo_reg <= (QUOT_BITS'(1) << FRACTION_BITS))
    `ASSERT_IMP(a_setup_mask, clk, rst_n, state_reg == ST_SETUP, mask_reg != 4'b0000)

endmodule

>>> tb/ccec_crossing_checker.sv
// Crossing checker: predicts crossing words from accepted samples and compares them.
module ccec_crossing_checker import ccec_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    ccec_sample_if                    samples,
    ccec_point_if                     points,
    output int                        failures,
    output int                        pending,
    output int                        words_checked
);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COL_BITS-1:0]   col;
        logic [ROW_BITS-1:0]   row;
        edge_t                 side;
        logic                  last;
    } crossing_t;

    crossing_t predicted_points[$];

    logic signed [SAMPLE_BITS-1:0] level;
    logic [SIZE_BITS-1:0]          columns_reg;
    logic [SIZE_BITS-1:0]          rows_reg;
    logic signed [SAMPLE_BITS-1:0] prev_row [MAX_COLUMNS] = '{default: '0};
    logic signed [SAMPLE_BITS-1:0] left_val;
    logic signed [SAMPLE_BITS-1:0] upper_left_val;
    int                            col_at;
    int                            row_at;

    function automatic int clamp_size(input int v, input int hi);
        if (v < 2)
        begin
            return 2;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic bit straddles(input longint a, input longint b, input longint lv);
        return (a <= lv && lv < b) || (b <= lv && lv < a);
    endfunction

    task automatic predict_cell_crossings(input logic signed [SAMPLE_BITS-1:0] s);
        logic signed [SAMPLE_BITS-1:0] above;
        longint                        corner [4];
        longint                        za;
        longint                        zb;
        longint                        lv;
        longint                        lv_gap;
        longint                        span;
        longint                        t;
        longint                        jx;
        longint                        iy;
        longint                        unit;
        longint                        px;
        longint                        py;
        crossing_t                     found [4];
        int                            n;
        int                            cols;
        int                            rows;
        above = prev_row[col_at];
        cols = clamp_size(int'(columns_reg), MAX_COLUMNS);
        rows = clamp_size(int'(rows_reg), MAX_ROWS);
        n = 0;
        if (row_at > 0 && col_at > 0)
        begin
            corner[0] = upper_left_val;
            corner[1] = above;
            corner[2] = s;
            corner[3] = left_val;
            lv = level;
            unit = longint'(1) << FRACTION_BITS;
            jx = longint'(col_at - 1) << FRACTION_BITS;
            iy = longint'(row_at - 1) << FRACTION_BITS;
            for (int k = 0; k < 4; k++)
            begin
                za = corner[k];
                zb = corner[(k + 1) % 4];
                if (straddles(za, zb, lv))
                begin
                    lv_gap = (lv > za) ? lv - za : za - lv;
                    span = (zb > za) ? zb - za : za - zb;
                    t = (lv_gap << FRACTION_BITS) / span;
                    case (edge_t'(k))
                        EDGE_TOP:
                        begin
                            px = jx + t;
                            py = iy;
                        end
                        EDGE_RIGHT:
                        begin
                            px = jx + unit;
                            py = iy + t;
                        end
                        EDGE_BOTTOM:
                        begin
                            px = jx + unit - t;
                            py = iy + unit;
                        end
                        default:
                        begin
                            px = jx;
                            py = iy + unit - t;
                        end
                    endcase
                    found[n].x = px[COORD_BITS-1:0];
                    found[n].y = py[COORD_BITS-1:0];
                    found[n].col = COL_BITS'(col_at - 1);
                    found[n].row = ROW_BITS'(row_at - 1);
                    found[n].side = edge_t'(k);
                    found[n].last = 1'b0;
                    n++;
                end
            end
            if (n > 0)
            begin
                found[n - 1].last = 1'b1;
            end
            for (int k = 0; k < n; k++)
            begin
                predicted_points = {predicted_points, found[k]};
            end
        end
        prev_row[col_at] = s;
        upper_left_val = above;
        left_val = s;
        if (col_at >= cols - 1)
        begin
            col_at = 0;
            if (row_at >= rows - 1)
            begin
                row_at = 0;
            end
            else
            begin
                row_at++;
            end
        end
        else
        begin
            col_at++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic compare_word();
        crossing_t want;
        if (predicted_points.size() == 0)
        begin
            failures++;
            $display("%0t unexpected crossing word: expected none, got x=%0d y=%0d edge=%0d",
                     $time, points.point_x, points.point_y, points.edge_id);
        end
        else
        begin
            want = predicted_points.pop_front();
            words_checked++;
            check_field("point_x", want.x, points.point_x);
            check_field("point_y", want.y, points.point_y);
            check_field("cell_column", want.col, points.cell_column);
            check_field("cell_row", want.row, points.cell_row);
            check_field("edge_id", want.side, points.edge_id);
            check_field("last_point", want.last, points.last_point);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level = '0;
            columns_reg = SIZE_BITS'(MAX_COLUMNS);
            rows_reg = SIZE_BITS'(MAX_ROWS);
            left_val = '0;
            upper_left_val = '0;
            col_at = 0;
            row_at = 0;
            predicted_points.delete();
            failures = 0;
            words_checked = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LEVEL:   level = cfg_data[SAMPLE_BITS-1:0];
                    CFG_COLUMNS: columns_reg = cfg_data[SIZE_BITS-1:0];
                    CFG_ROWS:    rows_reg = cfg_data[SIZE_BITS-1:0];
                    default:     ;
                endcase
            end
            if (points.valid && points.ready)
            begin
                compare_word();
            end
            if (samples.valid && samples.ready)
            begin
                predict_cell_crossings(samples.sample);
            end
            pending <= predicted_points.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// Testbench top: clock, reset, register setup, sample stimulus and verdict for the crossing core.
module tb_top;
    import ccec_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam int RANDOM_ITEMS  = 80;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 64;
    localparam int DRAIN_LIMIT   = 4000;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    int                        failures;
    int                        pending;
    int                        words_checked;
    int                        samples_sent;
    int                        settings_loaded;
    logic signed [SAMPLE_BITS-1:0] cur_level;
    bit                        sender_steady;
    bit                        receiver_steady;

    ccec_sample_if sample_ch ();
    ccec_point_if  point_ch ();

    contour_cell_edge_crossings_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_ch),
        .points    (point_ch)
    );

    ccec_crossing_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .samples       (sample_ch),
        .points        (point_ch),
        .failures      (failures),
        .pending       (pending),
        .words_checked (words_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_BITS-1:0] level_word,
                                 input logic [CFG_DATA_BITS-1:0] columns_word,
                                 input logic [CFG_DATA_BITS-1:0] rows_word,
                                 input bit [3:0] which);
        logic [CFG_INDEX_BITS-1:0] idx;
        for (int r = 0; r < 4; r++)
        begin
            if (which[r])
            begin
                idx = CFG_INDEX_BITS'(r);
                cfg_we <= 1'b1;
                cfg_index <= idx;
                case (idx)
                    CFG_LEVEL:   cfg_data <= level_word;
                    CFG_COLUMNS: cfg_data <= columns_word;
                    CFG_ROWS:    cfg_data <= rows_word;
                    default:     cfg_data <= CFG_DATA_BITS'($urandom);
                endcase
                @(posedge clk);
            end
        end
        cfg_we <= 1'b0;
        if (which[CFG_LEVEL])
        begin
            cur_level = level_word[SAMPLE_BITS-1:0];
        end
        settings_loaded++;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.sample <= value;
        do
            @(posedge clk);
        while (!(sample_ch.valid && sample_ch.ready));
        samples_sent++;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int near;
        case ($urandom_range(0, 7))
            0: return SAMPLE_BITS'($urandom);
            1: return cur_level;
            2: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            default:
            begin
                near = int'(cur_level) + int'($urandom_range(0, 600)) - 300;
                if (near > int'(SAMPLE_MAX))
                begin
                    near = int'(SAMPLE_MAX);
                end
                if (near < int'(SAMPLE_MIN))
                begin
                    near = int'(SAMPLE_MIN);
                end
                return near[SAMPLE_BITS-1:0];
            end
        endcase
    endfunction

    initial
    begin
        int stall;
        point_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = receiver_steady ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                point_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            point_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(point_ch.valid && point_ch.ready));
        end
    end

    initial
    begin
        int phase_len;
        int random_start;
        logic [CFG_DATA_BITS-1:0] level_word;
        logic [CFG_DATA_BITS-1:0] columns_word;
        logic [CFG_DATA_BITS-1:0] rows_word;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_LEVEL;
        cfg_data <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.sample <= '0;
        cur_level = '0;
        samples_sent = 0;
        settings_loaded = 0;
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // every edge of the first cell crossed, full-scale spans, level exactly on a corner
        wait_idle();
        load_settings(16'h0000, 16'd3, 16'd2, 4'b1111);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(16'sd0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd0);

        // lowest level: only corners strictly above it open an edge
        wait_idle();
        receiver_steady = 1'b1;
        load_settings(SAMPLE_MIN, 16'd2, 16'd2, 4'b0111);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd5);

        // highest level: nothing can lie above it, so no words
        wait_idle();
        sender_steady = 1'b1;
        receiver_steady = 1'b0;
        load_settings(SAMPLE_MAX, 16'd0, 16'd0, 4'b0001);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd0);
        send_sample(SAMPLE_MAX);

        // shrink the grid mid-frame, sizes below and above the legal range
        wait_idle();
        sender_steady = 1'b0;
        load_settings(16'h0155, 16'd4, 16'hFFFF, 4'b0111);
        repeat (7) send_sample(pick_sample());
        wait_idle();
        load_settings(16'h0000, 16'd0, 16'd1, 4'b0110);
        repeat (4) send_sample(pick_sample());

        random_start = samples_sent;
        while (samples_sent < random_start + RANDOM_ITEMS)
        begin
            wait_idle();
            sender_steady = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0:       level_word = SAMPLE_MIN;
                1:       level_word = SAMPLE_MAX;
                2:       level_word = CFG_DATA_BITS'($urandom);
                default: level_word = CFG_DATA_BITS'(int'($urandom_range(0, 2000)) - 1000);
            endcase
            columns_word = ($urandom_range(0, 7) == 0) ? CFG_DATA_BITS'($urandom)
                                                         : CFG_DATA_BITS'($urandom_range(0, 10));
            rows_word = ($urandom_range(0, 7) == 0) ? CFG_DATA_BITS'($urandom)
                                                      : CFG_DATA_BITS'($urandom_range(0, 6));
            load_settings(level_word, columns_word, rows_word, 4'($urandom_range(1, 15)));
            phase_len = $urandom_range(4, 24);
            for (int n = 0; n < phase_len; n++)
            begin
                if (n != 0 && $urandom_range(0, 11) == 0)
                begin
                    wait_idle();
                end
                send_sample(pick_sample());
            end
        end

        sample_ch.valid <= 1'b0;
        @(posedge clk);
        for (int c = 0; c < DRAIN_LIMIT && pending != 0; c++)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending != 0)
        begin
            $display("%0t crossing words missing: expected 0 outstanding, got %0d",
                     $time, pending);
        end
        $display("Streamed %0d samples under %0d register settings, clamped and resized grids.",
                 samples_sent, settings_loaded);
        $display("Compared %0d crossing words against predicted cell edges.", words_checked);
        if (failures == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ccec_pkg.sv
rtl/core/ccec_sample_if.sv
rtl/core/ccec_point_if.sv
rtl/core/contour_cell_edge_crossings_core.sv
tb/ccec_crossing_checker.sv
tb/tb_top.sv
